/* hdl/vwad_pkg.sv */
// Shared types, constants and step table for the variable-width ADPCM decoder.
package vwad_pkg;

	localparam logic [6:0] STEP_SPLIT = 7'd18;
	localparam logic [6:0] STEP_MAX   = 7'd79;
	localparam logic [6:0] INIT_RESET = 7'd40;
	localparam logic signed [11:0] PRED_MIN = -12'sd2048;
	localparam logic signed [11:0] PRED_MAX = 12'sd2047;
	localparam logic [1:0] LAST_SLOT  = 2'd3;
	localparam logic [1:0] ADDR_INITIAL_STEP = 2'd0;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       track_start;
	} code_item_t;

	typedef struct packed {
		logic signed [15:0] pcm_sample;
		logic               last_of_byte;
	} pcm_item_t;

	typedef struct packed {
		logic [6:0]         idx;
		logic signed [11:0] pred;
		logic [1:0]         slot;
		logic               last;
		logic               wide;
	} step_res_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	function automatic logic [6:0] load_step(input logic [6:0] v);
		return (v > STEP_MAX) ? STEP_MAX : v;
	endfunction

	function automatic logic [13:0] step_lookup(input logic [6:0] idx);
		logic [13:0] s;
		case (idx)
			7'd0: s = 14'd7;       7'd1: s = 14'd8;       7'd2: s = 14'd9;
			7'd3: s = 14'd10;      7'd4: s = 14'd11;      7'd5: s = 14'd12;
			7'd6: s = 14'd13;      7'd7: s = 14'd14;      7'd8: s = 14'd16;
			7'd9: s = 14'd17;      7'd10: s = 14'd19;     7'd11: s = 14'd21;
			7'd12: s = 14'd23;     7'd13: s = 14'd25;     7'd14: s = 14'd28;
			7'd15: s = 14'd31;     7'd16: s = 14'd34;     7'd17: s = 14'd37;
			7'd18: s = 14'd41;     7'd19: s = 14'd45;     7'd20: s = 14'd50;
			7'd21: s = 14'd55;     7'd22: s = 14'd60;     7'd23: s = 14'd66;
			7'd24: s = 14'd73;     7'd25: s = 14'd80;     7'd26: s = 14'd88;
			7'd27: s = 14'd97;     7'd28: s = 14'd107;    7'd29: s = 14'd118;
			7'd30: s = 14'd130;    7'd31: s = 14'd143;    7'd32: s = 14'd157;
			7'd33: s = 14'd173;    7'd34: s = 14'd190;    7'd35: s = 14'd209;
			7'd36: s = 14'd230;    7'd37: s = 14'd253;    7'd38: s = 14'd279;
			7'd39: s = 14'd307;    7'd40: s = 14'd337;    7'd41: s = 14'd371;
			7'd42: s = 14'd408;    7'd43: s = 14'd449;    7'd44: s = 14'd494;
			7'd45: s = 14'd544;    7'd46: s = 14'd598;    7'd47: s = 14'd658;
			7'd48: s = 14'd724;    7'd49: s = 14'd796;    7'd50: s = 14'd876;
			7'd51: s = 14'd963;    7'd52: s = 14'd1060;   7'd53: s = 14'd1166;
			7'd54: s = 14'd1282;   7'd55: s = 14'd1411;   7'd56: s = 14'd1552;
			7'd57: s = 14'd1707;   7'd58: s = 14'd1878;   7'd59: s = 14'd2066;
			7'd60: s = 14'd2272;   7'd61: s = 14'd2499;   7'd62: s = 14'd2749;
			7'd63: s = 14'd3024;   7'd64: s = 14'd3327;   7'd65: s = 14'd3660;
			7'd66: s = 14'd4026;   7'd67: s = 14'd4428;   7'd68: s = 14'd4871;
			7'd69: s = 14'd5358;   7'd70: s = 14'd5894;   7'd71: s = 14'd6484;
			7'd72: s = 14'd7132;   7'd73: s = 14'd7845;   7'd74: s = 14'd8630;
			7'd75: s = 14'd9493;   7'd76: s = 14'd10442;  7'd77: s = 14'd11487;
			7'd78: s = 14'd12635;
			default: s = 14'd13899;
		endcase
		return s;
	endfunction

endpackage

/* hdl/vwad_step.sv */
// Shared decode step: one code in, next step index and clamped predictor out.
module vwad_step (
	input  logic [6:0]         idx,
	input  logic signed [11:0] pred,
	input  logic [3:0]         code,
	input  logic [1:0]         slot,
	output vwad_pkg::step_res_t res
);
	import vwad_pkg::*;

	logic [13:0]        step;
	logic [15:0]        mag;
	logic               neg;
	logic signed [4:0]  mv;
	logic signed [16:0] diff;
	logic signed [17:0] sum;
	logic signed [7:0]  idx_sum;
	logic [2:0]         slot_sum;
	logic               wide;

	always_comb begin
		step = step_lookup(idx);
		// The top slot of a byte always holds a 2-bit code.
		wide = (idx >= STEP_SPLIT) && (slot != LAST_SLOT);
		mag  = {5'd0, step[13:3]};
		if (wide) begin
			if (code[0]) mag = mag + {4'd0, step[13:2]};
			if (code[1]) mag = mag + {3'd0, step[13:1]};
			if (code[2]) mag = mag + {2'd0, step};
			neg = code[3];
			mv  = code[2] ? $signed({2'b00, code[1:0], 1'b0}) + 5'sd2 : -5'sd1;
		end else begin
			if (code[0]) mag = mag + {2'd0, step};
			neg = code[1];
			mv  = code[0] ? 5'sd2 : -5'sd1;
		end
		diff = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		sum  = {{6{pred[11]}}, pred} + {diff[16], diff};

		idx_sum = $signed({1'b0, idx}) + {{3{mv[4]}}, mv};
		if (idx_sum < 8'sd0) begin
			res.idx = 7'd0;
		end else if (idx_sum > $signed({1'b0, STEP_MAX})) begin
			res.idx = STEP_MAX;
		end else begin
			res.idx = idx_sum[6:0];
		end

		if (sum < $signed({{6{PRED_MIN[11]}}, PRED_MIN})) begin
			res.pred = PRED_MIN;
		end else if (sum > $signed({6'd0, PRED_MAX})) begin
			res.pred = PRED_MAX;
		end else begin
			res.pred = sum[11:0];
		end

		slot_sum = {1'b0, slot} + (wide ? 3'd2 : 3'd1);
		res.slot = slot_sum[1:0];
		res.last = slot_sum[2];
		res.wide = wide;
	end

endmodule

/* hdl/variable_width_adpcm_decoder_core.sv */
// Top level of the variable-width ADPCM decoder with its configuration port.
// The core takes one packed code byte per transaction and decodes its codes from the least
// significant bit upward, giving two to four 16-bit PCM samples per byte; the final one carries
// last_of_byte. Samples are produced one per clock, while the sample output is not stalled, by a
// single shared decode step. code_stall stays high while a byte is being decoded and drops as the
// final sample is loaded into the output register, so the next byte can enter
// while that sample is still waiting to be taken. Setting track_start reloads the step index
// from initial_step (values above 79 act as 79) and clears the predictor before the byte is
// decoded. initial_step sits at address 0 and should be written only while the core is idle.
module variable_width_adpcm_decoder_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  code_valid,
	output logic                  code_stall,
	input  vwad_pkg::code_item_t  code_item,
	output logic                  pcm_valid,
	input  logic                  pcm_stall,
	output vwad_pkg::pcm_item_t   pcm_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [1:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import vwad_pkg::*;

	state_t             state_q;
	logic [6:0]         init_q;
	logic [6:0]         step_q;
	logic signed [11:0] pred_q;
	logic [7:0]         bits_q;
	logic [1:0]         slot_q;
	logic               out_valid_q;
	pcm_item_t          out_item_q;
	step_res_t          res;
	logic               accept;
	logic               advance;
	logic               cfg_write;

	vwad_step u_step (
		.idx  (step_q),
		.pred (pred_q),
		.code (bits_q[3:0]),
		.slot (slot_q),
		.res  (res)
	);

	assign accept    = code_valid && !code_stall;
	assign advance   = (state_q == ST_RUN) && (!out_valid_q || !pcm_stall);
	assign cfg_write = psel && penable && pwrite && pready;

	assign code_stall = (state_q != ST_IDLE);
	assign pcm_valid  = out_valid_q;
	assign pcm_item   = out_item_q;
	assign pready     = 1'b1;
	assign prdata     = (paddr == ADDR_INITIAL_STEP) ? {25'd0, init_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= INIT_RESET;
		end else if (cfg_write) begin
			init_q <= pwdata[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= INIT_RESET;
			pred_q      <= '0;
			bits_q      <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= ST_RUN;
				bits_q  <= code_item.code_byte;
				slot_q  <= '0;
				if (code_item.track_start) begin
					step_q <= load_step(init_q);
					pred_q <= '0;
				end
			end else if (advance) begin
				step_q <= res.idx;
				pred_q <= res.pred;
				slot_q <= res.slot;
				bits_q <= res.wide ? (bits_q >> 4) : (bits_q >> 2);
				if (res.last) begin
					state_q <= ST_IDLE;
				end
			end

			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!pcm_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.pcm_sample   <= {res.pred, 4'd0};
			out_item_q.last_of_byte <= res.last;
		end
	end

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_MAX)
		else $error("step index left the step table");

	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && pcm_valid |-> pcm_item.last_of_byte)
		else $error("decoder idle while a byte's samples are incomplete");

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_stall |=> (state_q == ST_RUN) && (slot_q == 2'd0))
		else $error("accepted byte did not start decoding");

endmodule

/* tb/tb_top.sv */
// Testbench for the variable-width ADPCM decoder core: directed and random byte streams.
`timescale 1ns / 1ps

module tb_top;
	import vwad_pkg::*;

	localparam int WIDE_FROM       = 18;
	localparam int STEP_TOP        = 79;
	localparam int PRED_LOW        = -2048;
	localparam int PRED_HIGH       = 2047;
	localparam int QUIET_LIMIT     = 2000;
	localparam int DRAIN_LIMIT     = 5000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 200;

	logic        clk;
	logic        arst_n;
	logic        code_valid;
	logic        code_stall;
	code_item_t  code_item;
	logic        pcm_valid;
	logic        pcm_stall;
	pcm_item_t   pcm_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int step_sizes [80] = '{
		7, 8, 9, 10, 11, 12, 13, 14, 16, 17,
		19, 21, 23, 25, 28, 31, 34, 37, 41, 45,
		50, 55, 60, 66, 73, 80, 88, 97, 107, 118,
		130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
		337, 371, 408, 449, 494, 544, 598, 658, 724, 796,
		876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066,
		2272, 2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358,
		5894, 6484, 7132, 7845, 8630, 9493, 10442, 11487, 12635, 13899
	};

	// Decoder state as the testbench tracks it.
	logic [6:0]         init_step_cfg = 7'd40;
	logic [6:0]         step_pos      = 7'd40;
	logic signed [11:0] pred_val      = '0;

	pcm_item_t expected_samples [$];
	int        error_count = 0;
	int        idle_pct    = 0;
	int        stall_pct   = 0;
	int        hold_request = 0;

	variable_width_adpcm_decoder_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_item  (code_item),
		.pcm_valid  (pcm_valid),
		.pcm_stall  (pcm_stall),
		.pcm_item   (pcm_item),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Decodes one byte against the tracked state and queues the samples it yields.
	function automatic void decode_byte(input logic [7:0] code_byte, input logic track_start);
		logic [7:0] bits;
		logic [3:0] c;
		int         pos;
		int         idx;
		int         stp;
		int         diff;
		int         sum;
		int         scaled;
		pcm_item_t  smp;
		bits = code_byte;
		pos  = 0;
		if (track_start) begin
			step_pos = (init_step_cfg > 7'(STEP_TOP)) ? 7'(STEP_TOP) : init_step_cfg;
			pred_val = '0;
		end
		while (pos < 8) begin
			idx  = int'(step_pos);
			stp  = step_sizes[idx];
			diff = stp >>> 3;
			if (idx < WIDE_FROM || pos > 4) begin
				c = {2'b00, bits[1:0]};
				if (c[0]) diff += stp;
				if (c[1]) diff = -diff;
				idx += c[0] ? 2 : -1;
				bits = bits >> 2;
				pos += 2;
			end else begin
				c = bits[3:0];
				if (c[0]) diff += stp >>> 2;
				if (c[1]) diff += stp >>> 1;
				if (c[2]) diff += stp;
				if (c[3]) diff = -diff;
				idx += c[2] ? 2 * (int'(c[1:0]) + 1) : -1;
				bits = bits >> 4;
				pos += 4;
			end
			if (idx < 0) idx = 0;
			if (idx > STEP_TOP) idx = STEP_TOP;
			step_pos = idx[6:0];
			sum = int'(pred_val) + diff;
			if (sum < PRED_LOW) sum = PRED_LOW;
			if (sum > PRED_HIGH) sum = PRED_HIGH;
			pred_val = sum[11:0];
			scaled = sum * 16;
			smp.pcm_sample   = scaled[15:0];
			smp.last_of_byte = (pos >= 8);
			expected_samples.insert(expected_samples.size(), smp);
		end
	endfunction

	// Offers one byte, with random idle cycles first, and returns after its transaction.
	task automatic send_code(input logic [7:0] code_byte, input logic track_start);
		code_item_t item;
		item.code_byte   = code_byte;
		item.track_start = track_start;
		while ($urandom_range(0, 99) < idle_pct) begin
			code_valid <= 1'b0;
			@(posedge clk);
		end
		code_valid <= 1'b1;
		code_item  <= item;
		@(negedge clk);
		while (code_stall) begin
			@(posedge clk);
			@(negedge clk);
		end
		decode_byte(code_byte, track_start);
		@(posedge clk);
	endtask

	// Waits for the core to go idle, then writes initial_step and reads it back.
	task automatic settle_and_configure(input logic [6:0] value);
		code_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_INITIAL_STEP;
		pwdata  <= {25'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		init_step_cfg = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata[6:0] !== value) begin
			$error("initial_step readback: expected %0d, actual %0d", value, prdata[6:0]);
			error_count++;
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_reset_state();
		// No track start: the decoder must run from its reset step index and predictor.
		send_code(8'h00, 1'b0);
		send_code(8'hFF, 1'b0);
	endtask

	task automatic test_code_extremes();
		// Largest positive codes push step index and predictor to their upper bounds; largest negative ones follow.
		send_code(8'h77, 1'b1);
		send_code(8'h77, 1'b0);
		send_code(8'h77, 1'b0);
		send_code(8'hFF, 1'b0);
		send_code(8'hFF, 1'b0);
	endtask

	task automatic test_narrow_codes();
		settle_and_configure(7'd0);
		// Starting from step index zero, every code stays narrow; the first byte holds the index at its lower bound.
		send_code(8'h00, 1'b1);
		send_code(8'h55, 1'b0);
		send_code(8'hAA, 1'b0);
		send_code(8'hFF, 1'b0);
		send_code(8'h33, 1'b0);
	endtask

	task automatic test_split_boundary();
		settle_and_configure(7'd17);
		send_code(8'h01, 1'b1);
		send_code(8'h0C, 1'b0);
		settle_and_configure(7'd18);
		send_code(8'h88, 1'b1);
		send_code(8'h00, 1'b0);
	endtask

	task automatic test_initial_step_saturation();
		settle_and_configure(7'd127);
		send_code(8'h5A, 1'b1);
		send_code(8'hC3, 1'b0);
		settle_and_configure(7'd80);
		send_code(8'h81, 1'b1);
		settle_and_configure(7'd79);
		send_code(8'h7F, 1'b1);
	endtask

	task automatic test_output_backpressure();
		idle_pct     = 0;
		stall_pct    = 0;
		hold_request = HOLD_OFF_CYCLES;
		send_code(8'($urandom_range(0, 255)), 1'b1);
		repeat (11) send_code(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic test_random_traffic(input int idle_p, input int stall_p, input int n_items);
		int         sent;
		int         track_left;
		logic       ts;
		logic [7:0] b;
		settle_and_configure(7'($urandom_range(0, 127)));
		idle_pct   = idle_p;
		stall_pct  = stall_p;
		sent       = 0;
		track_left = 0;
		while (sent < n_items) begin
			if (track_left == 0) begin
				track_left = $urandom_range(1, 12);
				ts = 1'b1;
			end else begin
				// Now and then a track restarts without warning.
				ts = ($urandom_range(0, 19) == 0);
			end
			track_left--;
			b = 8'($urandom_range(0, 255));
			send_code(b, ts);
			sent++;
		end
	endtask

	// Receiver side: random stalls, plus a long hold-off when one is requested.
	initial begin : sample_receiver
		int hold_left;
		hold_left = 0;
		pcm_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				pcm_stall <= 1'b1;
				hold_left--;
			end else begin
				pcm_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin : sample_checker
		pcm_item_t got;
		pcm_item_t want;
		forever begin
			@(negedge clk);
			if (arst_n && pcm_valid && !pcm_stall) begin
				got = pcm_item;
				if (expected_samples.size() == 0) begin
					$error("unexpected sample %0d, last_of_byte %0b",
						$signed(got.pcm_sample), got.last_of_byte);
					error_count++;
				end else begin
					want = expected_samples.pop_front();
					if (got.pcm_sample !== want.pcm_sample) begin
						$error("pcm_sample: expected %0d, actual %0d",
							$signed(want.pcm_sample), $signed(got.pcm_sample));
						error_count++;
					end
					if (got.last_of_byte !== want.last_of_byte) begin
						$error("last_of_byte: expected %0b, actual %0b",
							want.last_of_byte, got.last_of_byte);
						error_count++;
					end
				end
			end
		end
	end

	// Ends the run if no transaction happens on either channel for too long.
	initial begin : quiet_watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if (!arst_n || (code_valid && !code_stall) || (pcm_valid && !pcm_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : test_sequence
		int waited;
		arst_n     = 1'b0;
		code_valid = 1'b0;
		code_item  = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_code_extremes();
		test_narrow_codes();
		test_split_boundary();
		test_initial_step_saturation();
		test_output_backpressure();
		test_random_traffic(0, 0, 20);
		test_random_traffic(64, 0, 20);
		test_random_traffic(0, 64, 20);
		test_random_traffic(20, 20, 20);

		code_valid <= 1'b0;
		waited = 0;
		while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_samples.size() != 0) begin
			$error("%0d expected samples never arrived", expected_samples.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
